### rtl/bdss_pkg.sv
// ----------------------------------------------------------------------------
// bdss_pkg
// Shared types and codes for the bounded deque with search and sort: word
// layouts, request and status codes, datapath commands and controller states.
// ----------------------------------------------------------------------------
package bdss_pkg;

    // request codes
    localparam logic [3:0] REQ_PUSH_FRONT  = 4'd0;
    localparam logic [3:0] REQ_POP_FRONT   = 4'd1;
    localparam logic [3:0] REQ_PUSH_BACK   = 4'd2;
    localparam logic [3:0] REQ_POP_BACK    = 4'd3;
    localparam logic [3:0] REQ_SEARCH_FRNT = 4'd4;
    localparam logic [3:0] REQ_SEARCH_BACK = 4'd5;
    localparam logic [3:0] REQ_READ_OUT    = 4'd6;
    localparam logic [3:0] REQ_SIZE        = 4'd7;
    localparam logic [3:0] REQ_SORT        = 4'd8;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FOUND    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // input word
    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] value;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] item_value;
        logic [4:0]         entry_count;
        logic               last;
    } out_word_t;

    // datapath operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_PUSH_FRONT,
        DP_PUSH_BACK,
        DP_POP_FRONT,
        DP_POP_BACK,
        DP_IDX_CLEAR,
        DP_IDX_INC,
        DP_SRCH_READ,
        DP_OUT_READ,
        DP_OUT_EMIT,
        DP_SORT_KEY,
        DP_SORT_LOADKEY,
        DP_SORT_READ,
        DP_SORT_SHIFT,
        DP_SORT_PUT
    } dp_op_t;

    // controller to datapath
    typedef struct packed {
        dp_op_t  op;
        logic    emit_status;
        status_t status;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [3:0] req_type;
        logic       empty;
        logic       full;
        logic       lt_two;
        logic       match;
        logic       gt;
        logic       idx_last;
        logic       j_one;
        logic       i_last;
        logic       out_free;
    } dp_stat_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_OUT_RD,
        S_OUT_EMIT,
        S_SORT_KEY,
        S_SORT_KEYW,
        S_SORT_RD,
        S_SORT_CMP,
        S_SORT_PUT,
        S_DONE
    } state_t;

endpackage

### rtl/bdss_dp.sv
// ----------------------------------------------------------------------------
// bdss_dp
// Datapath: ring store memory, head pointer, entry count, walk counters,
// sort key and the result register.
// ----------------------------------------------------------------------------
module bdss_dp import bdss_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_word_t  s_data,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // ring store
    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0] wr_data;

    // control and payload registers
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic [3:0]    req_reg;
    logic [31:0]   val_reg;
    logic [31:0]   key_reg;
    logic          m_valid_reg, m_valid_next;
    out_word_t     m_data_reg, m_data_next;

    logic [AW-1:0] count_lo;
    logic [AW-1:0] srch_off;
    logic [AW-1:0] head_dec;
    logic          out_free;

    // physical slot of an offset from the front
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                            input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, off};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign count_lo = AW'(count_reg);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign srch_off = req_reg[0] ? (count_lo - 1'b1 - idx_reg) : idx_reg;
    assign out_free = !m_valid_reg || m_ready;

    // memory ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // next-state logic for the datapath registers
    always_comb begin
        head_next    = head_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        rd_en        = 1'b0;
        rd_addr      = slot(head_reg, idx_reg);
        wr_en        = 1'b0;
        wr_addr      = slot(head_reg, j_reg);
        wr_data      = rdata_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (cmd.op)
            DP_PUSH_FRONT: begin
                head_next  = head_dec;
                wr_en      = 1'b1;
                wr_addr    = head_dec;
                wr_data    = val_reg;
                count_next = count_reg + 1'b1;
            end
            DP_PUSH_BACK: begin
                wr_en      = 1'b1;
                wr_addr    = slot(head_reg, count_lo);
                wr_data    = val_reg;
                count_next = count_reg + 1'b1;
            end
            DP_POP_FRONT: begin
                count_next = count_reg - 1'b1;
                head_next  = (count_reg == CW'(1)) ? '0 : slot(head_reg, AW'(1));
            end
            DP_POP_BACK: begin
                count_next = count_reg - 1'b1;
                if (count_reg == CW'(1)) begin
                    head_next = '0;
                end
            end
            DP_IDX_CLEAR: begin
                idx_next = '0;
                i_next   = AW'(1);
            end
            DP_IDX_INC: begin
                idx_next = idx_reg + 1'b1;
            end
            DP_SRCH_READ: begin
                rd_en   = 1'b1;
                rd_addr = slot(head_reg, srch_off);
            end
            DP_OUT_READ: begin
                rd_en = 1'b1;
            end
            DP_OUT_EMIT: begin
                idx_next     = idx_reg + 1'b1;
                m_valid_next = 1'b1;
                m_data_next  = '{status: ST_OK, item_value: rdata_reg,
                                 entry_count: 5'(count_reg), last: stat.idx_last};
            end
            DP_SORT_KEY: begin
                rd_en   = 1'b1;
                rd_addr = slot(head_reg, i_reg);
                j_next  = i_reg;
            end
            DP_SORT_READ: begin
                rd_en   = 1'b1;
                rd_addr = slot(head_reg, j_reg - 1'b1);
            end
            DP_SORT_SHIFT: begin
                wr_en  = 1'b1;
                j_next = j_reg - 1'b1;
            end
            DP_SORT_PUT: begin
                wr_en   = 1'b1;
                wr_data = key_reg;
                i_next  = i_reg + 1'b1;
            end
            default: begin
            end
        endcase

        // single-result reply
        if (cmd.emit_status) begin
            m_valid_next = 1'b1;
            m_data_next  = '{status: cmd.status, item_value: '0,
                             entry_count: 5'(count_reg), last: 1'b1};
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        m_data_reg <= m_data_next;
        if (cmd.op == DP_CAPTURE) begin
            req_reg <= s_data.req_type;
            val_reg <= s_data.value;
        end
        if (cmd.op == DP_SORT_LOADKEY) begin
            key_reg <= rdata_reg;
        end
    end

    // status toward the controller
    always_comb begin
        stat.req_type = req_reg;
        stat.empty    = (count_reg == '0);
        stat.full     = (count_reg >= CW'(DEPTH));
        stat.lt_two   = (count_reg < CW'(2));
        stat.match    = (rdata_reg == val_reg);
        stat.gt       = ($signed(rdata_reg) > $signed(key_reg));
        stat.idx_last = (CW'(idx_reg) == count_reg - 1'b1);
        stat.j_one    = (j_reg == AW'(1));
        stat.i_last   = (CW'(i_reg) == count_reg - 1'b1);
        stat.out_free = out_free;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/bdss_ctrl.sv
// ----------------------------------------------------------------------------
// bdss_ctrl
// Controller: decodes each request and sequences the datapath through
// pushes, pops, searches, read-out and the insertion sort.
// ----------------------------------------------------------------------------
module bdss_ctrl import bdss_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t  state_reg, state_next;
    status_t status_reg, status_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // pending reply status
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
    end

    // next state and commands
    always_comb begin
        state_next      = state_reg;
        status_next     = status_reg;
        s_ready         = 1'b0;
        cmd.op          = DP_NOP;
        cmd.emit_status = 1'b0;
        cmd.status      = status_reg;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = DP_CAPTURE;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next  = S_DONE;
                status_next = ST_OK;
                case (stat.req_type)
                    REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                        if (stat.full) begin
                            status_next = ST_FULL;
                        end else begin
                            cmd.op = (stat.req_type == REQ_PUSH_FRONT) ?
                                     DP_PUSH_FRONT : DP_PUSH_BACK;
                        end
                    end
                    REQ_POP_FRONT, REQ_POP_BACK: begin
                        if (stat.empty) begin
                            status_next = ST_EMPTY;
                        end else begin
                            cmd.op = (stat.req_type == REQ_POP_FRONT) ?
                                     DP_POP_FRONT : DP_POP_BACK;
                        end
                    end
                    REQ_SEARCH_FRNT, REQ_SEARCH_BACK: begin
                        if (stat.empty) begin
                            status_next = ST_EMPTY;
                        end else begin
                            cmd.op     = DP_IDX_CLEAR;
                            state_next = S_SRCH_RD;
                        end
                    end
                    REQ_READ_OUT: begin
                        if (stat.empty) begin
                            status_next = ST_EMPTY;
                        end else begin
                            cmd.op     = DP_IDX_CLEAR;
                            state_next = S_OUT_RD;
                        end
                    end
                    REQ_SIZE: begin
                        status_next = stat.empty ? ST_EMPTY : ST_OK;
                    end
                    REQ_SORT: begin
                        if (!stat.lt_two) begin
                            cmd.op     = DP_IDX_CLEAR;
                            state_next = S_SORT_KEY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // search walk: a read state, then a compare state, per probe
            S_SRCH_RD: begin
                cmd.op     = DP_SRCH_READ;
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (stat.match) begin
                    status_next = ST_FOUND;
                    state_next  = S_DONE;
                end else if (stat.idx_last) begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end else begin
                    cmd.op     = DP_IDX_INC;
                    state_next = S_SRCH_RD;
                end
            end
            // read-out, one word per entry
            S_OUT_RD: begin
                cmd.op     = DP_OUT_READ;
                state_next = S_OUT_EMIT;
            end
            S_OUT_EMIT: begin
                if (stat.out_free) begin
                    cmd.op     = DP_OUT_EMIT;
                    state_next = stat.idx_last ? S_IDLE : S_OUT_RD;
                end
            end
            // insertion sort: fetch key, shift larger entries up, drop key in
            S_SORT_KEY: begin
                cmd.op     = DP_SORT_KEY;
                state_next = S_SORT_KEYW;
            end
            S_SORT_KEYW: begin
                cmd.op     = DP_SORT_LOADKEY;
                state_next = S_SORT_RD;
            end
            S_SORT_RD: begin
                cmd.op     = DP_SORT_READ;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                if (stat.gt) begin
                    cmd.op     = DP_SORT_SHIFT;
                    state_next = stat.j_one ? S_SORT_PUT : S_SORT_RD;
                end else begin
                    state_next = S_SORT_PUT;
                end
            end
            S_SORT_PUT: begin
                cmd.op = DP_SORT_PUT;
                if (stat.i_last) begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_SORT_KEY;
                end
            end
            // single reply once the result register is free
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.emit_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/bounded_deque_search_sort.sv
// ----------------------------------------------------------------------------
// bounded_deque_search_sort
// Bounded double-ended queue of signed 32-bit values in a ring store, with
// push/pop at both ends, search, size, read-out and in-place sort.
//
//   channel  ports                      word
//   input    s_valid s_ready s_data     req_type, value
//   result   m_valid m_ready m_data     status, item_value, entry_count, last
//
// One request at a time. Push, pop, size and empty cases pass through an
// execute state to a done state that loads the result word, then to idle.
// Search reads then compares each entry probed; read-out reads each entry
// and emits it, via the single read port of the ring store. Sort loads a key
// per inserted entry, then reads, compares and shifts up each larger entry
// ahead of it, and puts the key in. Reset clears head, count, the result
// valid flag and the controller state; the store needs no clearing. A stalled
// result register holds the controller before its next reply.
// ----------------------------------------------------------------------------
module bounded_deque_search_sort import bdss_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    bdss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // store and result register
    bdss_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
